>>> hw/rtl/ifp_pkg.sv
// Shared types, character codes and precedence function for the infix to postfix converter.
package ifp_pkg;

  typedef struct packed {
    logic       func;
    logic [7:0] ch;
  } ifp_in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    logic       error;
  } ifp_out_t;

  typedef struct packed {
    logic we;
    logic re;
  } ifp_mem_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_FIN,
    ST_EMIT
  } ifp_state_e;

  typedef enum logic [1:0] {
    MODE_CLOSE,
    MODE_OPER,
    MODE_FLUSH
  } ifp_mode_e;

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam ifp_out_t ERR_ITEM = '{out_char: 8'h00, last: 1'b0, error: 1'b1};

  function automatic logic [1:0] prec_of(input logic [7:0] c);
    logic [1:0] p;
    case (c) inside
      CH_PLUS, CH_MINUS:         p = 2'd1;
      CH_STAR, CH_SLASH, CH_PCT: p = 2'd2;
      default:                   p = 2'd0;
    endcase
    return p;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

>>> hw/rtl/ifp_stack_mem.sv
// Operator stack storage: single write port, registered read port.
module ifp_stack_mem
  import ifp_pkg::*;
#(
  parameter int STACK_DEPTH = 32,
  localparam int AW = $clog2(STACK_DEPTH)
) (
  input  logic          clk_i,
  input  ifp_mem_ctl_t  ctl_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rd_data_o
);

  logic [7:0] mem_q [STACK_DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rd_data_q <= mem_q[raddr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hw/rtl/ifp_ctrl.sv
// Shunting-yard sequencer: stack count, error mode, pop loop and output register.
module ifp_ctrl
  import ifp_pkg::*;
#(
  parameter int STACK_DEPTH = 32,
  localparam int AW = $clog2(STACK_DEPTH),
  localparam int CW = $clog2(STACK_DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  ifp_in_t       in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output ifp_out_t      out_o,
  output ifp_mem_ctl_t  mem_ctl_o,
  output logic [AW-1:0] waddr_o,
  output logic [7:0]    wdata_o,
  output logic [AW-1:0] raddr_o,
  input  logic [7:0]    rd_data_i,
  output logic [CW-1:0] count_o
);

  localparam logic [CW-1:0] FULL = CW'(STACK_DEPTH);

  ifp_state_e    state_q, state_d;
  ifp_mode_e     mode_q, mode_d;
  logic [7:0]    ch_q, ch_d;
  logic [CW-1:0] count_q, count_d;
  logic          err_seen_q, err_seen_d;
  ifp_out_t      pend_q, pend_d;
  ifp_out_t      out_q, out_d;
  logic          out_valid_q, out_valid_d;
  logic          out_load;
  ifp_out_t      out_load_data;

  logic in_fire;
  logic out_free;
  logic is_full;
  logic has_items;
  logic read_pop;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign is_full    = (count_q == FULL);
  assign has_items  = (count_q != '0);
  assign read_pop   = (state_q == ST_READ) &&
                      ((mode_q == MODE_FLUSH) ||
                       ((mode_q == MODE_CLOSE) && (rd_data_i != CH_LPAREN)) ||
                       ((mode_q == MODE_OPER) && (prec_of(ch_q) <= prec_of(rd_data_i))));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_i.func) begin
            state_d = (!err_seen_q && has_items) ? ST_READ : ST_EMIT;
          end else if (err_seen_q) begin
            state_d = ST_IDLE;
          end else if (is_digit(in_i.ch)) begin
            state_d = ST_EMIT;
          end else if (in_i.ch == CH_LPAREN) begin
            state_d = is_full ? ST_EMIT : ST_IDLE;
          end else begin
            state_d = has_items ? ST_READ : ST_FIN;
          end
        end
      end
      ST_READ: begin
        if (read_pop) begin
          if (out_free) begin
            state_d = (count_q > CW'(1)) ? ST_READ : ST_FIN;
          end
        end else if (mode_q == MODE_CLOSE) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if ((mode_q == MODE_OPER) && !is_full) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    mode_d        = mode_q;
    ch_d          = ch_q;
    count_d       = count_q;
    err_seen_d    = err_seen_q;
    pend_d        = pend_q;
    mem_ctl_o     = '0;
    waddr_o       = AW'(count_q);
    wdata_o       = ch_q;
    raddr_o       = AW'(count_q - CW'(1));
    out_load      = 1'b0;
    out_load_data = pend_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          ch_d = in_i.ch;
          if (in_i.func) begin
            mode_d = MODE_FLUSH;
          end else if (in_i.ch == CH_RPAREN) begin
            mode_d = MODE_CLOSE;
          end else begin
            mode_d = MODE_OPER;
          end
          if (in_i.func) begin
            if (err_seen_q) begin
              count_d    = '0;
              err_seen_d = 1'b0;
              pend_d     = '{out_char: 8'h00, last: 1'b1, error: 1'b1};
            end else if (has_items) begin
              mem_ctl_o.re = 1'b1;
            end else begin
              pend_d = '{out_char: 8'h00, last: 1'b1, error: 1'b0};
            end
          end else if (!err_seen_q) begin
            if (is_digit(in_i.ch)) begin
              pend_d = '{out_char: in_i.ch, last: 1'b0, error: 1'b0};
            end else if (in_i.ch == CH_LPAREN) begin
              if (is_full) begin
                pend_d     = ERR_ITEM;
                err_seen_d = 1'b1;
              end else begin
                mem_ctl_o.we = 1'b1;
                wdata_o      = in_i.ch;
                count_d      = count_q + CW'(1);
              end
            end else if (has_items) begin
              mem_ctl_o.re = 1'b1;
            end
          end
        end
      end
      ST_READ: begin
        if (read_pop) begin
          if (out_free) begin
            out_load      = 1'b1;
            out_load_data = '{out_char: rd_data_i, last: 1'b0, error: 1'b0};
            count_d       = count_q - CW'(1);
            if (count_q > CW'(1)) begin
              mem_ctl_o.re = 1'b1;
              raddr_o      = AW'(count_q - CW'(2));
            end
          end
        end else if (mode_q == MODE_CLOSE) begin
          count_d = count_q - CW'(1);
        end
      end
      ST_FIN: begin
        unique case (mode_q)
          MODE_CLOSE: begin
            pend_d     = ERR_ITEM;
            err_seen_d = 1'b1;
          end
          MODE_OPER: begin
            if (is_full) begin
              pend_d     = ERR_ITEM;
              err_seen_d = 1'b1;
            end else begin
              mem_ctl_o.we = 1'b1;
              count_d      = count_q + CW'(1);
            end
          end
          MODE_FLUSH: begin
            pend_d = '{out_char: 8'h00, last: 1'b1, error: 1'b0};
          end
          default: pend_d = pend_q;
        endcase
      end
      ST_EMIT: begin
        out_load = out_free;
      end
      default: out_load = 1'b0;
    endcase
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_d       = out_load_data;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= MODE_OPER;
      count_q     <= '0;
      err_seen_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      count_q     <= count_d;
      err_seen_q  <= err_seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    pend_q <= pend_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign count_o     = count_q;

endmodule

>>> hw/rtl/infix_to_postfix_converter.sv
// Top level of the infix to postfix converter: sequencer plus operator stack memory.
//
// Input channel in_valid_i/in_ready_o carries one item: func selects an expression
// character (0) or an end-of-expression flush (1), ch holds the character byte.
// Output channel out_valid_o/out_ready_i carries postfix characters, error items
// and the terminator (last set, out_char 0) that closes every expression.
// Items are taken one at a time. A '(' is pushed on acceptance; an operator,
// ')' or flush pops stacked entries before it is finished; the pop loop runs
// at one entry per cycle while the output register can take it, paced by the
// registered read port of the stack memory. A digit or error item is loaded
// into the output register from ST_EMIT, a popped entry from ST_READ.
// A finished result sits in the output register; a new item is accepted while
// it waits, and the block stalls only when it needs to hand over another result.
// After an overflow or underflow an error item is sent and expression characters
// are dropped until the next flush, which empties the stack and sends a
// terminator with error set. Reset empties the stack and leaves error mode; no
// clearing pass is needed.
module infix_to_postfix_converter
  import ifp_pkg::*;
#(
  parameter int STACK_DEPTH = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  ifp_in_t  in_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ifp_out_t out_o
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  ifp_mem_ctl_t  mem_ctl;
  logic [AW-1:0] waddr;
  logic [7:0]    wdata;
  logic [AW-1:0] raddr;
  logic [7:0]    rd_data;
  logic [CW-1:0] count;

  ifp_ctrl #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o),
    .mem_ctl_o  (mem_ctl),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .raddr_o    (raddr),
    .rd_data_i  (rd_data),
    .count_o    (count)
  );

  ifp_stack_mem #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_stack_mem (
    .clk_i    (clk_i),
    .ctl_i    (mem_ctl),
    .waddr_i  (waddr),
    .wdata_i  (wdata),
    .raddr_i  (raddr),
    .rd_data_o(rd_data)
  );

`ifndef SYNTHESIS
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctl.we && mem_ctl.re))
    else $error("stack read and write in the same cycle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_push_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_ctl.we |=> (count == $past(count) + CW'(1)))
    else $error("push without count increment");

  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.last) |-> (out_o.out_char == 8'h00))
    else $error("terminator with nonzero character");
`endif

endmodule
